FILE: rtl/oga_pkg.sv
// shared types, constants and helpers for the odometry gyro accumulator
`timescale 1ns / 1ps
package oga_pkg;
   localparam int RateW  = 24;
   localparam int DtW    = 20;
   localparam int AccW   = 48;
   localparam int CntW   = 32;
   localparam int SigW   = 23;
   localparam int TauW   = 32;
   localparam int ProdW  = RateW + DtW + 2;
   localparam int DivW   = 50;
   localparam int DenW   = 33;
   localparam logic [TauW-1:0] TauFloor = TauW'(1049);

   localparam logic [2:0] RegEnable = 3'd0;
   localparam logic [2:0] RegLimit  = 3'd1;
   localparam logic [2:0] RegTau    = 3'd2;
   localparam logic [2:0] RegPreint = 3'd3;
   localparam logic [2:0] RegSigma  = 3'd4;

   typedef struct packed {
      logic                   enable;
      logic [SigW-1:0]        limit;
      logic [TauW-1:0]        tau;
      logic                   preint;
      logic [SigW-1:0]        sigma;
   } cfg_type;

   function automatic logic signed [AccW-1:0] sat_s48(input logic signed [AccW:0] s);
      logic signed [AccW-1:0] r;
      r = s[AccW-1:0];
      if (s[AccW] != s[AccW-1]) r = s[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
      return r;
   endfunction

   function automatic logic [AccW-1:0] sat_u48(input logic [AccW:0] s);
      return s[AccW] ? {AccW{1'b1}} : s[AccW-1:0];
   endfunction
endpackage

FILE: rtl/oga_serial_mul.sv
// shift-add multiplier, one multiplier bit per cycle, signed multiplicand
`timescale 1ns / 1ps
module oga_serial_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [oga_pkg::RateW:0]    mcand,
   input  logic [oga_pkg::DtW+2:0]           mplier,
   output logic                              done,
   output logic signed [oga_pkg::ProdW+3:0]  product
);
   import oga_pkg::*;
   localparam int MW = DtW + 3;
   localparam int PW = ProdW + 4;
   logic signed [PW-1:0] acc_ff, acc_in, mc_ff, mc_in;
   logic [MW-1:0] mp_ff, mp_in;
   logic [4:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      acc_in = acc_ff; mc_in = mc_ff; mp_in = mp_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         acc_in = '0; mc_in = PW'(mcand); mp_in = mplier;
         cnt_in = 5'(MW); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mp_ff[0]) acc_in = acc_ff + mc_ff;
         mc_in = mc_ff <<< 1;
         mp_in = mp_ff >> 1;
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in; mc_ff <= mc_in; mp_ff <= mp_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end
   assign done = done_ff;
   assign product = acc_ff;
endmodule

FILE: rtl/oga_serial_div.sv
// restoring divider, one quotient bit per cycle, rounds half away from zero
`timescale 1ns / 1ps
module oga_serial_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [oga_pkg::DivW-1:0]          mag,
   input  logic [oga_pkg::DenW-1:0]          den,
   output logic                              done,
   output logic [oga_pkg::DivW-1:0]          quot
);
   import oga_pkg::*;
   logic [DivW-1:0] q_ff, q_in;
   logic [DenW:0] r_ff, r_in, t;
   logic [DenW-1:0] d_ff, d_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      t = {r_ff[DenW-1:0], q_ff[DivW-1]};
      if (start) begin
         q_in = mag + DivW'(den >> 1); r_in = '0; d_in = den;
         cnt_in = 6'(DivW); busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in = {q_ff[DivW-2:0], 1'b0};
         r_in = t;
         if (t >= {1'b0, d_ff}) begin
            r_in = t - {1'b0, d_ff}; q_in[0] = 1'b1;
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end
   assign done = done_ff;
   assign quot = q_ff;
endmodule

FILE: rtl/odometry_gyro_accumulator.sv
// top level: csr port, sequencer and accumulators for wheel and gyro items
// sequence: a wheel item runs three serial products (x, y, yaw) before rsp_valid; an ignored item goes to S_RESP
// a gyro item runs one to four serial products, with a bias division only when the bias is updated
// handshake: one item at a time, next item taken the cycle after the result is accepted
// reset: synchronous active high, clears accumulators, csr to defaults
`timescale 1ns / 1ps
module odometry_gyro_accumulator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic signed [23:0]            req_vel_x,
   input  logic signed [23:0]            req_vel_y,
   input  logic signed [23:0]            req_yaw_rate,
   input  logic [19:0]                   req_interval,
   input  logic                          req_stationary_flag,
   input  logic signed [23:0]            req_graph_bias,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [47:0]            rsp_sum_x,
   output logic signed [47:0]            rsp_sum_y,
   output logic signed [47:0]            rsp_sum_yaw_wheel,
   output logic signed [47:0]            rsp_sum_yaw_gyro,
   output logic [47:0]                   rsp_sum_time,
   output logic [23:0]                   rsp_peak_rate,
   output logic signed [23:0]            rsp_bias_estimate,
   output logic [31:0]                   rsp_bias_update_count,
   output logic signed [47:0]            rsp_preint_yaw,
   output logic [47:0]                   rsp_preint_time,
   output logic [47:0]                   rsp_preint_variance,
   output logic                          rsp_ignored,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [4:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import oga_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE = 11'b00000000001, S_MX   = 11'b00000000010, S_MY  = 11'b00000000100,
      S_MW   = 11'b00000001000, S_BMUL = 11'b00000010000, S_BDIV = 11'b00000100000,
      S_CMUL = 11'b00001000000, S_SMUL = 11'b00010000000, S_VMUL = 11'b00100000000,
      S_RESP = 11'b01000000000, S_WAIT = 11'b10000000000
   } state_type;

   state_type st_ff, st_in;
   cfg_type cfg_ff, cfg_in;
   logic [RateW-1:0] vy_ff, wz_ff, gb_ff;
   logic [DtW-1:0] dt_ff;
   logic stat_ff;
   logic signed [AccW-1:0] ax_ff, ay_ff, aw_ff, ag_ff, py_ff;
   logic [AccW-1:0] at_ff, pt_ff, pv_ff;
   logic [RateW-1:0] mx_ff;
   logic signed [RateW-1:0] bv_ff;
   logic [CntW-1:0] bu_ff;
   logic ign_ff, rv_ff;
   logic signed [AccW-1:0] ax_in, ay_in, aw_in, ag_in, py_in;
   logic [AccW-1:0] at_in, pt_in, pv_in;
   logic [RateW-1:0] mx_in;
   logic signed [RateW-1:0] bv_in;
   logic [CntW-1:0] bu_in;
   logic ign_in, rv_in;
   logic bneg_ff, bneg_in;

   logic mstart, mdone, dstart, ddone;
   logic signed [RateW:0] mcand;
   logic [DtW+2:0] mplier;
   logic signed [ProdW+3:0] prod;
   logic signed [ProdW+3:0] rnd;
   logic [DivW-1:0] dmag, quot;
   logic [DenW-1:0] dden;
   logic signed [RateW:0] wz_s, mag_s, corr;
   logic [RateW-1:0] mag;
   logic [TauW-1:0] tau_u;
   logic wr;
   logic req_fire;

   oga_serial_mul u_mul (.clock, .reset, .start(mstart), .mcand, .mplier,
                         .done(mdone), .product(prod));
   oga_serial_div u_div (.clock, .reset, .start(dstart), .mag(dmag), .den(dden),
                         .done(ddone), .quot);

   assign req_ready = (st_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign wz_s = {wz_ff[RateW-1], wz_ff};
   assign mag_s = wz_s[RateW] ? -wz_s : wz_s;
   assign mag = mag_s[RateW-1:0];
   assign corr = cfg_ff.preint ? {gb_ff[RateW-1], gb_ff} :
                 (cfg_ff.enable ? {bv_ff[RateW-1], bv_ff} : '0);
   assign rnd = (prod + (ProdW+4)'(1 << 19)) >>> 20;
   assign tau_u = (cfg_ff.tau < TauFloor) ? TauFloor : cfg_ff.tau;
   assign dden = DenW'(tau_u) + DenW'(dt_ff);
   assign dmag = prod[ProdW+3] ? DivW'(-prod) : DivW'(prod);

   assign wr = psel && penable && pwrite;
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (paddr[4:2])
            RegEnable: cfg_in.enable = pwdata[0];
            RegLimit:  cfg_in.limit  = pwdata[SigW-1:0];
            RegTau:    cfg_in.tau    = pwdata;
            RegPreint: cfg_in.preint = pwdata[0];
            RegSigma:  cfg_in.sigma  = pwdata[SigW-1:0];
            default: ;
         endcase
      end
      case (paddr[4:2])
         RegEnable: prdata = 32'(cfg_ff.enable);
         RegLimit:  prdata = 32'(cfg_ff.limit);
         RegTau:    prdata = cfg_ff.tau;
         RegPreint: prdata = 32'(cfg_ff.preint);
         RegSigma:  prdata = 32'(cfg_ff.sigma);
         default:   prdata = '0;
      endcase
   end
   assign pready = 1'b1;

   always_comb begin
      st_in = st_ff; mstart = 1'b0; dstart = 1'b0;
      mcand = '0; mplier = 23'(dt_ff);
      ax_in = ax_ff; ay_in = ay_ff; aw_in = aw_ff; ag_in = ag_ff; py_in = py_ff;
      at_in = at_ff; pt_in = pt_ff; pv_in = pv_ff; mx_in = mx_ff; bv_in = bv_ff;
      bu_in = bu_ff; ign_in = ign_ff; rv_in = rv_ff; bneg_in = bneg_ff;
      case (st_ff)
         S_IDLE: begin
            if (req_fire) begin
               ign_in = (req_interval == '0);
               if (req_interval == '0) st_in = S_RESP;
               else if (!req_kind) begin
                  mstart = 1'b1; mcand = {req_vel_x[23], req_vel_x};
                  mplier = 23'(req_interval); st_in = S_MX;
               end else st_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (mag > mx_ff) mx_in = mag;
            if (cfg_ff.enable && stat_ff && ({1'b0, mag} < {2'b0, cfg_ff.limit})) begin
               mstart = 1'b1; mcand = wz_s - {bv_ff[RateW-1], bv_ff}; st_in = S_BMUL;
            end else begin
               mstart = 1'b1; mcand = wz_s - corr; st_in = S_CMUL;
            end
         end
         S_MX: if (mdone) begin
            ax_in = sat_s48((AccW+1)'(ax_ff) + (AccW+1)'(rnd));
            mstart = 1'b1; mcand = {vy_ff[23], vy_ff}; st_in = S_MY;
         end
         S_MY: if (mdone) begin
            ay_in = sat_s48((AccW+1)'(ay_ff) + (AccW+1)'(rnd));
            mstart = 1'b1; mcand = wz_s; st_in = S_MW;
         end
         S_MW: if (mdone) begin
            aw_in = sat_s48((AccW+1)'(aw_ff) + (AccW+1)'(rnd));
            at_in = sat_u48({1'b0, at_ff} + (AccW+1)'(dt_ff));
            st_in = S_RESP;
         end
         S_BMUL: if (mdone) begin
            bneg_in = prod[ProdW+3]; dstart = 1'b1; st_in = S_BDIV;
         end
         S_BDIV: if (ddone) begin
            bv_in = bneg_ff ? bv_ff - RateW'(quot) : bv_ff + RateW'(quot);
            if (bu_ff != '1) bu_in = bu_ff + CntW'(1);
            mstart = 1'b1;
            mcand = cfg_ff.preint ? wz_s - {gb_ff[RateW-1], gb_ff} :
                    wz_s - {bv_in[RateW-1], bv_in};
            st_in = S_CMUL;
         end
         S_CMUL: begin
            if (mdone) begin
               ag_in = sat_s48((AccW+1)'(ag_ff) + (AccW+1)'(rnd));
               if (cfg_ff.preint) begin
                  py_in = sat_s48((AccW+1)'(py_ff) + (AccW+1)'(rnd));
                  pt_in = sat_u48({1'b0, pt_ff} + (AccW+1)'(dt_ff));
                  mstart = 1'b1; mcand = {2'b0, cfg_ff.sigma}; st_in = S_SMUL;
               end else st_in = S_RESP;
            end
         end
         S_SMUL: if (mdone) begin
            mstart = 1'b1; mcand = {1'b0, rnd[23:0]}; mplier = rnd[22:0];
            st_in = S_VMUL;
         end
         S_VMUL: if (mdone) begin
            pv_in = sat_u48({1'b0, pv_ff} + (AccW+1)'(prod));
            st_in = S_RESP;
         end
         S_RESP: begin
            rv_in = 1'b1;
            if (rv_ff && rsp_ready) begin
               rv_in = 1'b0; st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         vy_ff <= req_vel_y;
         wz_ff <= req_yaw_rate; dt_ff <= req_interval;
         stat_ff <= req_stationary_flag; gb_ff <= req_graph_bias;
      end
      bneg_ff <= bneg_in; ign_ff <= ign_in;
      if (reset) begin
         st_ff <= S_IDLE; rv_ff <= 1'b0;
         cfg_ff <= '{enable: 1'b0, limit: 23'd3277, tau: 32'd1048576,
                     preint: 1'b0, sigma: 23'd66};
         ax_ff <= '0; ay_ff <= '0; aw_ff <= '0; ag_ff <= '0; py_ff <= '0;
         at_ff <= '0; pt_ff <= '0; pv_ff <= '0; mx_ff <= '0; bv_ff <= '0; bu_ff <= '0;
      end else begin
         st_ff <= st_in; rv_ff <= rv_in; cfg_ff <= cfg_in;
         ax_ff <= ax_in; ay_ff <= ay_in; aw_ff <= aw_in; ag_ff <= ag_in; py_ff <= py_in;
         at_ff <= at_in; pt_ff <= pt_in; pv_ff <= pv_in; mx_ff <= mx_in;
         bv_ff <= bv_in; bu_ff <= bu_in;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_sum_x = ax_ff;
   assign rsp_sum_y = ay_ff;
   assign rsp_sum_yaw_wheel = aw_ff;
   assign rsp_sum_yaw_gyro = ag_ff;
   assign rsp_sum_time = at_ff;
   assign rsp_peak_rate = mx_ff;
   assign rsp_bias_estimate = bv_ff;
   assign rsp_bias_update_count = bu_ff;
   assign rsp_preint_yaw = py_ff;
   assign rsp_preint_time = pt_ff;
   assign rsp_preint_variance = pv_ff;
   assign rsp_ignored = ign_ff;
endmodule
